[sv/tlb_page_translate_defines.svh]
// ---------------------------------------------------------------------------
// tlb_page_translate_defines: assertion macros
// Shared concurrent assertion forms used by the translation block.
// ---------------------------------------------------------------------------
`ifndef TLB_PAGE_TRANSLATE_DEFINES_SVH
`define TLB_PAGE_TRANSLATE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, idle during reset.
`define TPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, idle during reset.
`define TPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tpt_pkg.sv]
// ---------------------------------------------------------------------------
// tpt_pkg: shared definitions for the page translation block
// Sizes, field widths, codes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package tpt_pkg;

    localparam int PAGE_BYTES  = 256;
    localparam int TLB_ENTRIES = 16;
    localparam int FRAMES      = 16;
    localparam int PAGES       = 64;

    localparam int VA_W      = 14;
    localparam int PA_W      = 12;
    localparam int VP_OUT_W  = 6;
    localparam int LF_OUT_W  = 4;
    localparam int OFF_W     = $clog2(PAGE_BYTES);
    localparam int VPN_W     = VA_W - OFF_W;
    localparam int PAGE_W    = $clog2(PAGES);
    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TLB_ENABLE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 1'd1;

    localparam logic MODE_WRITE  = 1'b1;
    localparam logic POLICY_FIFO = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT,
        ST_LOAD,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic evict;
        logic load;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic addr_err;
        logic tlb_hit;
        logic page_resident;
    } t_sts;

endpackage

[sv/tlb_page_translate.sv]
// ---------------------------------------------------------------------------
// tlb_page_translate: virtual to physical translation with TLB and paging
// One item at a time. After the accept, a TLB hit or an address error goes from
// lookup straight to the result, a page walk of a resident page passes through
// update, and a page fault through evict, load and update; the result holds there
// until it is taken. The next item is taken in the cycle after the result.
// Reset is synchronous, active low: TLB empty, pages 0..FRAMES-1 resident.
// ---------------------------------------------------------------------------
module tlb_page_translate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [tpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                           i_cfg_data,
    // Input channel.
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_mode,
    input  logic [tpt_pkg::VA_W-1:0]       i_virtual_address,
    // Result channel.
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tpt_pkg::PA_W-1:0]       o_physical_address,
    output logic                           o_tlb_hit,
    output logic                           o_page_fault,
    output logic                           o_writeback_needed,
    output logic [tpt_pkg::VP_OUT_W-1:0]   o_victim_page,
    output logic [tpt_pkg::LF_OUT_W-1:0]   o_load_frame,
    output logic                           o_address_error
);
    import tpt_pkg::*;

    // The controller walks each item through the steps below; the datapath
    // holds all translation state.
    //   lookup: fully associative TLB search and page table read result.
    //   evict:  victim frame's page is dropped from the TLB and page table,
    //           and its dirty bit is read.
    //   load:   faulting page takes the victim frame; writeback is decided.
    //   update: LRU ranks are touched and, with the TLB enabled, it is refilled,
    //           using a free entry first and a clock scan over reference bits otherwise.
    t_cmd cmd;
    t_sts sts;

    tpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tpt_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_mode             (i_mode),
        .i_virtual_address  (i_virtual_address),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_writeback_needed (o_writeback_needed),
        .o_victim_page      (o_victim_page),
        .o_load_frame       (o_load_frame),
        .o_address_error    (o_address_error)
    );

endmodule

[sv/tpt_ctrl.sv]
// ---------------------------------------------------------------------------
// tpt_ctrl: translation sequencer
// Steps one item through lookup, eviction, load and update.
// ---------------------------------------------------------------------------
module tpt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  tpt_pkg::t_sts i_sts,
    output tpt_pkg::t_cmd o_cmd
);
    import tpt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (i_sts.addr_err || i_sts.tlb_hit) n_state = ST_DONE;
                else if (i_sts.page_resident)        n_state = ST_UPDATE;
                else                                 n_state = ST_EVICT;
            end
            ST_EVICT:  n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_DONE;
            ST_DONE: begin
                if (i_ready) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_LOOKUP: o_cmd.lookup = 1'b1;
            ST_EVICT:  o_cmd.evict  = 1'b1;
            ST_LOAD:   o_cmd.load   = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            ST_DONE:   o_valid      = 1'b1;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

[sv/tpt_dp.sv]
// ---------------------------------------------------------------------------
// tpt_dp: translation datapath
// TLB, page table memories, frame ownership, replacement state and results.
// ---------------------------------------------------------------------------
`include "tlb_page_translate_defines.svh"

module tpt_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tpt_pkg::t_cmd                  i_cmd,
    output tpt_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_we,
    input  logic [tpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                           i_cfg_data,
    input  logic                           i_mode,
    input  logic [tpt_pkg::VA_W-1:0]       i_virtual_address,
    output logic [tpt_pkg::PA_W-1:0]       o_physical_address,
    output logic                           o_tlb_hit,
    output logic                           o_page_fault,
    output logic                           o_writeback_needed,
    output logic [tpt_pkg::VP_OUT_W-1:0]   o_victim_page,
    output logic [tpt_pkg::LF_OUT_W-1:0]   o_load_frame,
    output logic                           o_address_error
);
    import tpt_pkg::*;

    // Configuration.
    logic r_tlb_en;
    logic r_policy;

    // Current item.
    logic               r_mode;
    logic [PAGE_W-1:0]  r_page;
    logic [OFF_W-1:0]   r_off;
    logic               r_addr_err;

    // Result and working registers.
    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] r_victim;
    logic [PAGE_W-1:0]  r_vpage;
    logic               r_vtlb_dirty;
    logic               r_hit;
    logic               r_fault;
    logic               r_wb;

    // TLB.
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [TLB_ENTRIES-1:0] r_tlb_ref;
    logic [TLB_ENTRIES-1:0] r_tlb_dirty;
    logic [PAGE_W-1:0]      r_tlb_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_tlb_frame [TLB_ENTRIES];

    // Frame state.
    logic [PAGE_W-1:0]  r_owner [FRAMES];
    logic [FRAME_W-1:0] r_rank  [FRAMES];
    logic [FRAME_W-1:0] r_fifo;

    // Page table memories: {valid, frame} and the dirty bit. An entry that
    // was never written reads as its reset value.
    logic [FRAME_W:0]   r_pvf_mem   [PAGES];
    logic [PAGES-1:0]   r_pvf_wr;
    logic [FRAME_W:0]   r_pvf_q;
    logic               r_pvf_fresh;
    logic               r_dirty_mem [PAGES];
    logic [PAGES-1:0]   r_dirty_wr;
    logic               r_dirty_q;
    logic               r_dirty_fresh;

    logic [VPN_W-1:0]   in_vpn;
    logic [PAGE_W-1:0]  in_page;
    logic               pvf_valid;
    logic [FRAME_W-1:0] pvf_frame;
    logic               dirty_val;
    logic               pvf_we;
    logic [PAGE_W-1:0]  pvf_waddr;
    logic [FRAME_W:0]   pvf_wdata;
    logic               dirty_we;
    logic [PAGE_W-1:0]  dirty_waddr;
    logic               dirty_wdata;
    logic               hit_any;
    logic [TLB_IDX_W-1:0] hit_idx;
    logic               vm_any;
    logic [TLB_IDX_W-1:0] vm_idx;
    logic [PAGE_W-1:0]  vp;
    logic [FRAME_W-1:0] lru_oldest;
    logic [FRAME_W-1:0] victim;
    logic               free_any;
    logic [TLB_IDX_W-1:0] free_idx;
    logic [TLB_IDX_W-1:0] clk_idx;
    logic [TLB_IDX_W-1:0] fill_idx;
    logic               walk_write;

    assign in_vpn  = i_virtual_address[VA_W-1:OFF_W];
    assign in_page = PAGE_W'(in_vpn);
    assign vp      = r_owner[r_victim];

    assign pvf_valid = r_pvf_fresh ? (32'(r_page) < FRAMES) : r_pvf_q[FRAME_W];
    assign pvf_frame = r_pvf_fresh ? ((32'(r_page) < FRAMES) ? FRAME_W'(r_page) : '0)
                                   : r_pvf_q[FRAME_W-1:0];
    assign dirty_val = !r_dirty_fresh && r_dirty_q;

    assign o_sts.addr_err      = r_addr_err;
    assign o_sts.tlb_hit       = !r_addr_err && r_tlb_en && hit_any;
    assign o_sts.page_resident = pvf_valid;

    // Associative searches: the lowest matching entry wins.
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        vm_any   = 1'b0;
        vm_idx   = '0;
        free_any = 1'b0;
        free_idx = '0;
        clk_idx  = TLB_IDX_W'(TLB_ENTRIES - 1);
        for (int e = TLB_ENTRIES - 1; e >= 0; e--) begin
            if (r_tlb_valid[e] && r_tlb_page[e] == r_page) begin
                hit_any = 1'b1;
                hit_idx = TLB_IDX_W'(e);
            end
            if (r_tlb_valid[e] && r_tlb_page[e] == vp) begin
                vm_any = 1'b1;
                vm_idx = TLB_IDX_W'(e);
            end
            if (!r_tlb_valid[e]) begin
                free_any = 1'b1;
                free_idx = TLB_IDX_W'(e);
            end
        end
        // Clock scan over a full TLB: first clear ref bit, else the last entry.
        for (int e = TLB_ENTRIES - 2; e >= 0; e--) begin
            if (!r_tlb_ref[e]) clk_idx = TLB_IDX_W'(e);
        end
    end

    assign fill_idx = free_any ? free_idx : clk_idx;

    // The ranks are a permutation, so the oldest frame holds the top rank.
    always_comb begin
        lru_oldest = '0;
        for (int g = FRAMES - 1; g >= 0; g--) begin
            if (r_rank[g] == FRAME_W'(FRAMES - 1)) lru_oldest = FRAME_W'(g);
        end
    end

    assign victim     = (r_policy == POLICY_FIFO) ? r_fifo : lru_oldest;
    assign walk_write = i_cmd.lookup && !r_addr_err && !o_sts.tlb_hit && pvf_valid
                        && (r_mode == MODE_WRITE);

    always_comb begin
        pvf_we    = 1'b0;
        pvf_waddr = r_page;
        pvf_wdata = {1'b1, r_victim};
        if (i_cmd.evict) begin
            pvf_we    = 1'b1;
            pvf_waddr = vp;
            pvf_wdata = '0;
        end else if (i_cmd.load) begin
            pvf_we    = 1'b1;
        end
    end

    always_comb begin
        dirty_we    = 1'b0;
        dirty_waddr = r_page;
        dirty_wdata = 1'b1;
        if (walk_write) begin
            dirty_we    = 1'b1;
        end else if (i_cmd.load) begin
            dirty_we    = 1'b1;
            dirty_wdata = r_mode;
        end else if (i_cmd.update && r_tlb_en && !free_any && r_tlb_dirty[clk_idx]) begin
            dirty_we    = 1'b1;
            dirty_waddr = r_tlb_page[clk_idx];
        end
    end

    // Memory arrays and their registered reads.
    always_ff @(posedge i_clk) begin
        if (pvf_we)   r_pvf_mem[pvf_waddr]     <= pvf_wdata;
        if (dirty_we) r_dirty_mem[dirty_waddr] <= dirty_wdata;
        if (i_cmd.accept) begin
            r_pvf_q     <= r_pvf_mem[in_page];
            r_pvf_fresh <= !r_pvf_wr[in_page];
        end
        if (i_cmd.evict) begin
            r_dirty_q     <= r_dirty_mem[vp];
            r_dirty_fresh <= !r_dirty_wr[vp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvf_wr   <= '0;
            r_dirty_wr <= '0;
        end else begin
            if (pvf_we)   r_pvf_wr[pvf_waddr]     <= 1'b1;
            if (dirty_we) r_dirty_wr[dirty_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_en <= 1'b1;
            r_policy <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TLB_ENABLE:     r_tlb_en <= i_cfg_data;
                CFG_REPLACE_POLICY: r_policy <= i_cfg_data;
                default:            r_tlb_en <= r_tlb_en;
            endcase
        end
    end

    // Item and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode     <= i_mode;
            r_page     <= in_page;
            r_off      <= i_virtual_address[OFF_W-1:0];
            r_addr_err <= (32'(in_vpn) >= PAGES);
        end
        if (i_cmd.lookup) begin
            r_hit    <= o_sts.tlb_hit;
            r_fault  <= 1'b0;
            r_wb     <= 1'b0;
            r_vpage  <= '0;
            r_victim <= victim;
            r_frame  <= o_sts.tlb_hit ? r_tlb_frame[hit_idx] : pvf_frame;
        end
        if (i_cmd.evict) begin
            r_vpage      <= vp;
            r_vtlb_dirty <= vm_any && r_tlb_dirty[vm_idx];
        end
        if (i_cmd.load) begin
            r_wb    <= dirty_val || r_vtlb_dirty;
            r_fault <= 1'b1;
            r_frame <= r_victim;
        end
    end

    // Frame ownership, FIFO pointer and LRU ranks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < FRAMES; f++) begin
                r_owner[f] <= PAGE_W'(f);
                r_rank[f]  <= FRAME_W'(FRAMES - 1 - f);
            end
            r_fifo <= FRAME_W'(FRAMES - 1);
        end else begin
            if (i_cmd.load) begin
                r_owner[r_victim] <= r_page;
                if (r_policy == POLICY_FIFO) begin
                    r_fifo <= (r_victim == '0) ? FRAME_W'(FRAMES - 1) : r_victim - 1'b1;
                end
            end
            if (i_cmd.update) begin
                for (int g = 0; g < FRAMES; g++) begin
                    if (r_rank[g] < r_rank[r_frame]) r_rank[g] <= r_rank[g] + 1'b1;
                end
                r_rank[r_frame] <= '0;
            end
        end
    end

    // TLB state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_valid <= '0;
            r_tlb_ref   <= '0;
            r_tlb_dirty <= '0;
            for (int e = 0; e < TLB_ENTRIES; e++) begin
                r_tlb_page[e]  <= '0;
                r_tlb_frame[e] <= '0;
            end
        end else begin
            if (i_cmd.lookup && o_sts.tlb_hit) begin
                r_tlb_ref[hit_idx] <= 1'b1;
                if (r_mode == MODE_WRITE) r_tlb_dirty[hit_idx] <= 1'b1;
            end
            if (i_cmd.evict && vm_any) begin
                r_tlb_valid[vm_idx] <= 1'b0;
            end
            if (i_cmd.update && r_tlb_en) begin
                for (int e = 0; e < TLB_ENTRIES; e++) begin
                    if (!free_any && TLB_IDX_W'(e) < clk_idx) r_tlb_ref[e] <= 1'b0;
                end
                r_tlb_page[fill_idx]  <= r_page;
                r_tlb_frame[fill_idx] <= r_frame;
                r_tlb_dirty[fill_idx] <= 1'b0;
                r_tlb_ref[fill_idx]   <= 1'b1;
                r_tlb_valid[fill_idx] <= 1'b1;
            end
        end
    end

    assign o_physical_address = r_addr_err ? '0 : PA_W'({r_frame, r_off});
    assign o_tlb_hit          = r_hit;
    assign o_page_fault       = r_fault;
    assign o_writeback_needed = r_wb;
    assign o_victim_page      = VP_OUT_W'(r_vpage);
    assign o_load_frame       = r_fault ? LF_OUT_W'(r_victim) : '0;
    assign o_address_error    = r_addr_err;

    `TPT_ASSERT_IMP(a_hit_excludes_fault, i_cmd.update, !r_hit, "walk after a TLB hit")
    `TPT_ASSERT_NXT(a_touch_is_mru, i_cmd.update, r_rank[$past(r_frame)] == '0, "touched frame not MRU")
    `TPT_ASSERT_NXT(a_owner_loaded, i_cmd.load, r_owner[$past(r_victim)] == $past(r_page), "owner not updated on load")

endmodule
